[hw/rtl/lmd_pkg.sv]
// Shared types, constants and window helpers for the 3x3 local-maximum detector.
package lmd_pkg;

    localparam int MAX_WIDTH   = 1024;
    localparam int ROW_LIMIT   = 4096;
    localparam int PIX_W       = 8;
    localparam int COL_W       = $clog2(MAX_WIDTH);
    localparam int ROW_W       = $clog2(ROW_LIMIT);
    localparam int CFG_WIDTH_W = 11;
    localparam int CFG_HEIGHT_W = 13;
    localparam int APB_ADDR_W  = 3;
    localparam int APB_DATA_W  = 32;
    localparam int NUM_RES     = 4;

    // Register index, taken from paddr[2]
    localparam logic REG_IDX_WIDTH  = 1'b0;
    localparam logic REG_IDX_HEIGHT = 1'b1;

    localparam logic [CFG_WIDTH_W-1:0]  WIDTH_RESET  = CFG_WIDTH_W'(640);
    localparam logic [CFG_HEIGHT_W-1:0] HEIGHT_RESET = CFG_HEIGHT_W'(480);

    // Window entry k = row*3 + col, row 0 on top
    typedef logic [8:0][PIX_W-1:0] win_t;

    typedef struct packed {
        logic [ROW_W-1:0] row;
        logic [COL_W-1:0] col;
        logic [PIX_W-1:0] value;
        logic             is_max;
        logic             last;
    } res_t;

    function automatic logic win_is_max(input win_t w);
        logic flag;
        flag = 1'b1;
        for (int i = 0; i < 9; i++) begin
            if (i != 4 && w[4] < w[i]) begin
                flag = 1'b0;
            end
        end
        return flag;
    endfunction

    function automatic win_t win_shift_left(input win_t w);
        win_t o;
        for (int r = 0; r < 3; r++) begin
            o[r*3+0] = w[r*3+1];
            o[r*3+1] = w[r*3+2];
            o[r*3+2] = '0;
        end
        return o;
    endfunction

    function automatic win_t win_shift_up(input win_t w);
        win_t o;
        for (int k = 0; k < 6; k++) begin
            o[k] = w[k+3];
        end
        for (int k = 6; k < 9; k++) begin
            o[k] = '0;
        end
        return o;
    endfunction

endpackage

[hw/rtl/local_max_3x3_detector_unit.sv]
// Top level of the streaming 3x3 local-maximum (non-maximum suppression) detector.
//
// Pixels enter in raster order on in_valid/in_stall/pixel, one transaction per
// pixel, frame size set by the frame_width and frame_height registers on the
// APB port (width at 0x0, height at 0x4). Any register write restarts the frame.
// Each centre is reported on out_valid/out_stall with row, column, value and the
// local-max flag once its 3x3 window is complete; pixels outside the frame count
// as zero. last_of_run marks the final result caused by one input pixel.
// Inside the frame one pixel is taken per clock unless the receiver stalls. A
// pixel gives 0 or 1 results, except at the right edge and on the bottom row,
// where up to 4 come out, one per clock, and input waits for them. A pixel's
// first result passes through an input stage holding the line-buffer read,
// then a four-entry result buffer that feeds the output.
// Both line buffers live in one 16-bit-wide RAM read at the pixel's column;
// rows above the first are masked to zero, so no clearing pass is needed.
// Reset restores width 640, height 480 and empties the pipeline. When the
// receiver stalls, the result buffer holds, one more pixel waits in the input
// stage, and in_stall then rises.
module local_max_3x3_detector_unit (
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic                           in_valid,
    output logic                           in_stall,
    input  logic [lmd_pkg::PIX_W-1:0]      pixel,
    output logic                           out_valid,
    input  logic                           out_stall,
    output logic [lmd_pkg::ROW_W-1:0]      centre_row,
    output logic [lmd_pkg::COL_W-1:0]      centre_col,
    output logic [lmd_pkg::PIX_W-1:0]      centre_value,
    output logic                           is_local_max,
    output logic                           last_of_run,
    input  logic                           psel,
    input  logic                           penable,
    input  logic                           pwrite,
    input  logic [lmd_pkg::APB_ADDR_W-1:0] paddr,
    input  logic [lmd_pkg::APB_DATA_W-1:0] pwdata,
    output logic [lmd_pkg::APB_DATA_W-1:0] prdata,
    output logic                           pready
);

    import lmd_pkg::*;

    // Configuration
    logic [CFG_WIDTH_W-1:0]  width_reg;
    logic [CFG_HEIGHT_W-1:0] height_reg;
    logic [CFG_WIDTH_W-1:0]  eff_width;
    logic [CFG_HEIGHT_W-1:0] eff_height;
    logic                    cfg_wr;

    // Input side counters
    logic [COL_W-1:0] col_reg, col_next;
    logic [ROW_W-1:0] row_reg, row_next;
    logic             in_accept;
    logic             in_last_col;
    logic             in_last_row;

    // Input stage
    logic                   s1_valid_reg;
    logic [PIX_W-1:0]       s1_pixel_reg;
    logic [COL_W-1:0]       s1_col_reg;
    logic [ROW_W-1:0]       s1_row_reg;
    logic                   s1_last_col_reg;
    logic                   s1_last_row_reg;
    logic                   s1_fwd_reg;
    logic [2*PIX_W-1:0]     s1_fwd_data_reg;
    logic                   s1_adv;
    logic                   fwd_next;

    logic [2*PIX_W-1:0] ram_rdata;
    logic [2*PIX_W-1:0] line_data;
    logic [PIX_W-1:0]   top;
    logic [PIX_W-1:0]   mid;

    win_t window_reg;
    win_t win_base;
    win_t win_new;
    win_t win_l;
    win_t win_u;
    win_t win_lu;

    // Result buffer
    res_t [NUM_RES-1:0] res_reg;
    res_t [NUM_RES-1:0] res_new;
    logic [NUM_RES-1:0] mask_reg, mask_next;
    logic [NUM_RES-1:0] cond;
    logic [NUM_RES-1:0] head_oh;
    logic [NUM_RES-1:0] mask_popped;
    res_t               head;
    logic               out_take;

    // ---------------- configuration port ----------------
    assign pready = 1'b1;
    assign cfg_wr = psel && penable && pwrite && pready;

    always_comb
    begin
        case (paddr[2])
            REG_IDX_WIDTH:  prdata = APB_DATA_W'(width_reg);
            REG_IDX_HEIGHT: prdata = APB_DATA_W'(height_reg);
            default:        prdata = '0;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            width_reg  <= WIDTH_RESET;
            height_reg <= HEIGHT_RESET;
        end
        else if (cfg_wr)
        begin
            case (paddr[2])
                REG_IDX_WIDTH:  width_reg  <= pwdata[CFG_WIDTH_W-1:0];
                REG_IDX_HEIGHT: height_reg <= pwdata[CFG_HEIGHT_W-1:0];
                default:        width_reg  <= width_reg;
            endcase
        end
    end

    always_comb
    begin
        if (width_reg == '0)
            eff_width = CFG_WIDTH_W'(1);
        else if (width_reg > CFG_WIDTH_W'(MAX_WIDTH))
            eff_width = CFG_WIDTH_W'(MAX_WIDTH);
        else
            eff_width = width_reg;

        if (height_reg == '0)
            eff_height = CFG_HEIGHT_W'(1);
        else if (height_reg > CFG_HEIGHT_W'(ROW_LIMIT))
            eff_height = CFG_HEIGHT_W'(ROW_LIMIT);
        else
            eff_height = height_reg;
    end

    // ---------------- input side ----------------
    assign in_stall  = s1_valid_reg && !s1_adv;
    assign in_accept = in_valid && !in_stall;

    assign in_last_col = (CFG_WIDTH_W'(col_reg) + CFG_WIDTH_W'(1)) == eff_width;
    assign in_last_row = (CFG_HEIGHT_W'(row_reg) + CFG_HEIGHT_W'(1)) == eff_height;

    always_comb
    begin
        col_next = col_reg;
        row_next = row_reg;
        if (in_accept)
        begin
            if (in_last_col)
            begin
                col_next = '0;
                row_next = in_last_row ? '0 : row_reg + ROW_W'(1);
            end
            else
            begin
                col_next = col_reg + COL_W'(1);
            end
        end
        if (cfg_wr)
        begin
            col_next = '0;
            row_next = '0;
        end
    end

    // Same column read while the previous pixel writes it (width of one)
    assign fwd_next = s1_valid_reg && s1_adv && (s1_col_reg == col_reg);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            col_reg      <= '0;
            row_reg      <= '0;
            s1_valid_reg <= 1'b0;
            s1_fwd_reg   <= 1'b0;
        end
        else
        begin
            col_reg <= col_next;
            row_reg <= row_next;
            if (in_accept)
            begin
                s1_valid_reg <= 1'b1;
                s1_fwd_reg   <= fwd_next;
            end
            else if (s1_adv)
            begin
                s1_valid_reg <= 1'b0;
                s1_fwd_reg   <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_accept)
        begin
            s1_pixel_reg    <= pixel;
            s1_col_reg      <= col_reg;
            s1_row_reg      <= row_reg;
            s1_last_col_reg <= in_last_col;
            s1_last_row_reg <= in_last_row;
            s1_fwd_data_reg <= {mid, s1_pixel_reg};
        end
    end

    // Upper byte: two rows above, lower byte: row above
    lmd_ram #(
        .WIDTH (2*PIX_W),
        .DEPTH (MAX_WIDTH)
    ) u_line_ram (
        .clk   (clk),
        .we    (s1_adv),
        .waddr (s1_col_reg),
        .wdata ({mid, s1_pixel_reg}),
        .re    (in_accept),
        .raddr (col_reg),
        .rdata (ram_rdata)
    );

    // ---------------- window and evaluation ----------------
    assign line_data = s1_fwd_reg ? s1_fwd_data_reg : ram_rdata;
    assign top = (s1_row_reg >= ROW_W'(2)) ? line_data[2*PIX_W-1:PIX_W] : '0;
    assign mid = (s1_row_reg != '0) ? line_data[PIX_W-1:0] : '0;

    always_comb
    begin
        win_base = (s1_col_reg == '0) ? '0 : window_reg;
        for (int r = 0; r < 3; r++)
        begin
            win_new[r*3+0] = win_base[r*3+1];
            win_new[r*3+1] = win_base[r*3+2];
        end
        win_new[2] = top;
        win_new[5] = mid;
        win_new[8] = s1_pixel_reg;
    end

    assign win_l  = win_shift_left(win_new);
    assign win_u  = win_shift_up(win_new);
    assign win_lu = win_shift_up(win_l);

    always_ff @(posedge clk)
    begin
        if (s1_adv)
        begin
            window_reg <= win_new;
        end
    end

    // Order: (r-1,c-1), (r-1,c), (r,c-1), (r,c)
    assign cond[0] = (s1_row_reg != '0) && (s1_col_reg != '0);
    assign cond[1] = (s1_row_reg != '0) && s1_last_col_reg;
    assign cond[2] = s1_last_row_reg && (s1_col_reg != '0);
    assign cond[3] = s1_last_row_reg && s1_last_col_reg;

    always_comb
    begin
        res_new[0].row    = s1_row_reg - ROW_W'(1);
        res_new[0].col    = s1_col_reg - COL_W'(1);
        res_new[0].value  = win_new[4];
        res_new[0].is_max = win_is_max(win_new);
        res_new[1].row    = s1_row_reg - ROW_W'(1);
        res_new[1].col    = s1_col_reg;
        res_new[1].value  = win_l[4];
        res_new[1].is_max = win_is_max(win_l);
        res_new[2].row    = s1_row_reg;
        res_new[2].col    = s1_col_reg - COL_W'(1);
        res_new[2].value  = win_u[4];
        res_new[2].is_max = win_is_max(win_u);
        res_new[3].row    = s1_row_reg;
        res_new[3].col    = s1_col_reg;
        res_new[3].value  = win_lu[4];
        res_new[3].is_max = win_is_max(win_lu);
        res_new[0].last   = cond[0] && (cond[3:1] == '0);
        res_new[1].last   = cond[1] && (cond[3:2] == '0);
        res_new[2].last   = cond[2] && !cond[3];
        res_new[3].last   = cond[3];
    end

    // ---------------- result buffer ----------------
    always_comb
    begin
        head_oh = '0;
        head    = res_reg[0];
        for (int i = NUM_RES - 1; i >= 0; i--)
        begin
            if (mask_reg[i])
            begin
                head_oh = NUM_RES'(1) << i;
                head    = res_reg[i];
            end
        end
    end

    assign out_take    = out_valid && !out_stall;
    assign mask_popped = out_take ? (mask_reg & ~head_oh) : mask_reg;
    assign s1_adv      = s1_valid_reg && (mask_popped == '0);
    assign mask_next   = s1_adv ? cond : mask_popped;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mask_reg <= '0;
        end
        else
        begin
            mask_reg <= mask_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (s1_adv)
        begin
            res_reg <= res_new;
        end
    end

    assign out_valid    = (mask_reg != '0);
    assign centre_row   = head.row;
    assign centre_col   = head.col;
    assign centre_value = head.value;
    assign is_local_max = head.is_max;
    assign last_of_run  = head.last;

    // ---------------- assertions ----------------
    a_col_in_frame: assert property (@(posedge clk) disable iff (!rst_n)
        (CFG_WIDTH_W'(col_reg) < eff_width))
        else $error("column counter beyond frame width");

    a_row_in_frame: assert property (@(posedge clk) disable iff (!rst_n)
        (CFG_HEIGHT_W'(row_reg) < eff_height))
        else $error("row counter beyond frame height");

    a_fwd_only_narrow: assert property (@(posedge clk) disable iff (!rst_n)
        s1_fwd_reg |-> (eff_width == CFG_WIDTH_W'(1)))
        else $error("line forwarding used on a frame wider than one column");

    a_stage_holds: assert property (@(posedge clk) disable iff (!rst_n)
        (s1_valid_reg && !s1_adv) |=> (s1_valid_reg && $stable(s1_col_reg)))
        else $error("input stage lost a pixel while the result buffer was busy");

    a_last_marked: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && ($countones(mask_reg) == 1)) |-> last_of_run)
        else $error("final result of a pixel not marked last");

endmodule

[hw/rtl/lmd_ram.sv]
// Simple dual-port RAM, one write and one registered read port.
module lmd_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 1024
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic                     re,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem_reg[waddr] <= wdata;
        end
        if (re)
        begin
            rdata_reg <= mem_reg[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

[tb/tb_local_max_3x3_detector_unit.sv]
// Self-checking testbench for the streaming 3x3 local-maximum detector.
module tb_local_max_3x3_detector_unit;

    timeunit 1ns;
    timeprecision 1ps;

    import lmd_pkg::*;

    localparam logic [APB_ADDR_W-1:0] WIDTH_ADDR  = {REG_IDX_WIDTH, 2'b00};
    localparam logic [APB_ADDR_W-1:0] HEIGHT_ADDR = {REG_IDX_HEIGHT, 2'b00};
    localparam int RANDOM_PIXELS = 260;
    localparam int EDGE_PIXELS   = 60;

    logic                  clk       = 1'b0;
    logic                  rst_n     = 1'b0;
    logic                  in_valid  = 1'b0;
    logic                  in_stall;
    logic [PIX_W-1:0]      pixel     = '0;
    logic                  out_valid;
    logic                  out_stall = 1'b0;
    logic [ROW_W-1:0]      centre_row;
    logic [COL_W-1:0]      centre_col;
    logic [PIX_W-1:0]      centre_value;
    logic                  is_local_max;
    logic                  last_of_run;
    logic                  psel      = 1'b0;
    logic                  penable   = 1'b0;
    logic                  pwrite    = 1'b0;
    logic [APB_ADDR_W-1:0] paddr     = '0;
    logic [APB_DATA_W-1:0] pwdata    = '0;
    logic [APB_DATA_W-1:0] prdata;
    logic                  pready;

    // Shadow of the detector: frame registers, line stores, window, raster position
    logic [CFG_WIDTH_W-1:0]  cfg_width  = WIDTH_RESET;
    logic [CFG_HEIGHT_W-1:0] cfg_height = HEIGHT_RESET;
    logic [PIX_W-1:0]        one_row_up  [MAX_WIDTH];
    logic [PIX_W-1:0]        two_rows_up [MAX_WIDTH];
    logic [PIX_W-1:0]        nbhd [9];
    int unsigned             row_pos = 0;
    int unsigned             col_pos = 0;

    res_t pending_centres [$];
    int   mismatches     = 0;
    int   pixels_sent    = 0;
    int   centres_seen   = 0;
    int   maxima_seen    = 0;
    int   settings_used  = 0;
    bit   source_calm    = 1'b0;
    bit   sink_calm      = 1'b0;

    local_max_3x3_detector_unit u_dut (
        .clk          (clk),
        .rst_n        (rst_n),
        .in_valid     (in_valid),
        .in_stall     (in_stall),
        .pixel        (pixel),
        .out_valid    (out_valid),
        .out_stall    (out_stall),
        .centre_row   (centre_row),
        .centre_col   (centre_col),
        .centre_value (centre_value),
        .is_local_max (is_local_max),
        .last_of_run  (last_of_run),
        .psel         (psel),
        .penable      (penable),
        .pwrite       (pwrite),
        .paddr        (paddr),
        .pwdata       (pwdata),
        .prdata       (prdata),
        .pready       (pready)
    );

    always #5 clk = ~clk;

    initial
    begin
        for (int i = 0; i < MAX_WIDTH; i++)
        begin
            one_row_up[i]  = '0;
            two_rows_up[i] = '0;
        end
        for (int k = 0; k < 9; k++)
        begin
            nbhd[k] = '0;
        end
    end

    function automatic int unsigned active_width();
        if (cfg_width == 0)
            return 1;
        if (cfg_width > MAX_WIDTH)
            return MAX_WIDTH;
        return cfg_width;
    endfunction

    function automatic int unsigned active_height();
        if (cfg_height == 0)
            return 1;
        if (cfg_height > ROW_LIMIT)
            return ROW_LIMIT;
        return cfg_height;
    endfunction

    // Centre of the current window, optionally moved one column left and/or one row
    // up with zeros coming in from outside the frame.
    function automatic res_t make_centre(input int dr, input int dc,
                                         input int unsigned r, input int unsigned c);
        res_t             res;
        logic [PIX_W-1:0] v [3][3];
        for (int i = 0; i < 3; i++)
        begin
            for (int j = 0; j < 3; j++)
            begin
                v[i][j] = (i + dr < 3 && j + dc < 3) ? nbhd[(i + dr) * 3 + j + dc] : '0;
            end
        end
        res.row    = ROW_W'(r);
        res.col    = COL_W'(c);
        res.value  = v[1][1];
        res.is_max = 1'b1;
        res.last   = 1'b0;
        for (int i = 0; i < 3; i++)
        begin
            for (int j = 0; j < 3; j++)
            begin
                if ((i != 1 || j != 1) && v[i][j] > v[1][1])
                    res.is_max = 1'b0;
            end
        end
        return res;
    endfunction

    task automatic predict_centres(input logic [PIX_W-1:0] px);
        int unsigned      w_eff;
        int unsigned      h_eff;
        int unsigned      r;
        int unsigned      c;
        logic [PIX_W-1:0] top;
        logic [PIX_W-1:0] mid;
        bit               end_col;
        bit               end_row;
        res_t             batch [$];
        w_eff = active_width();
        h_eff = active_height();
        r = row_pos;
        c = col_pos;
        if (c >= w_eff)
            c = 0;
        if (r >= h_eff)
            r = 0;
        if (c == 0)
        begin
            for (int k = 0; k < 9; k++)
                nbhd[k] = '0;
        end
        // rows above the first read as zero whatever the stores hold
        top = (r >= 2) ? two_rows_up[c] : '0;
        mid = (r >= 1) ? one_row_up[c] : '0;
        two_rows_up[c] = mid;
        one_row_up[c]  = px;
        for (int i = 0; i < 3; i++)
        begin
            nbhd[i * 3]     = nbhd[i * 3 + 1];
            nbhd[i * 3 + 1] = nbhd[i * 3 + 2];
        end
        nbhd[2] = top;
        nbhd[5] = mid;
        nbhd[8] = px;

        end_col = (c + 1 == w_eff);
        end_row = (r + 1 == h_eff);
        if (r >= 1 && c >= 1)
            batch.push_back(make_centre(0, 0, r - 1, c - 1));
        if (r >= 1 && end_col)
            batch.push_back(make_centre(0, 1, r - 1, c));
        if (end_row && c >= 1)
            batch.push_back(make_centre(1, 0, r, c - 1));
        if (end_row && end_col)
            batch.push_back(make_centre(1, 1, r, c));
        if (batch.size() > 0)
            batch[batch.size() - 1].last = 1'b1;
        foreach (batch[k])
            pending_centres.push_back(batch[k]);

        if (end_col)
        begin
            col_pos = 0;
            row_pos = end_row ? 0 : r + 1;
        end
        else
        begin
            col_pos = c + 1;
            row_pos = r;
        end
    endtask

    task automatic report_centre(input string what, input res_t want, input res_t got);
        if (mismatches < 10)
            $display({"%0t %s: expected row %0d col %0d value %0d max %0b last %0b,",
                      " got row %0d col %0d value %0d max %0b last %0b"},
                     $time, what, want.row, want.col, want.value, want.is_max, want.last,
                     got.row, got.col, got.value, got.is_max, got.last);
        mismatches++;
    endtask

    // Result checker: every transaction on the output side against the oldest prediction
    always @(posedge clk)
    begin : check_centres
        res_t got;
        res_t want;
        if (rst_n && out_valid && !out_stall)
        begin
            got = '{row: centre_row, col: centre_col, value: centre_value,
                    is_max: is_local_max, last: last_of_run};
            centres_seen++;
            if (is_local_max)
                maxima_seen++;
            if (pending_centres.size() == 0)
            begin
                report_centre("unexpected centre", '0, got);
            end
            else
            begin
                want = pending_centres.pop_front();
                if (got.row !== want.row || got.col !== want.col
                    || got.value !== want.value || got.is_max !== want.is_max
                    || got.last !== want.last)
                    report_centre("centre mismatch", want, got);
            end
        end
    end

    // Receiver: random stall before each transaction, with calm stretches
    initial
    begin : result_sink
        int hold;
        wait (rst_n === 1'b1);
        @(posedge clk);
        forever
        begin
            if ($urandom_range(0, 31) == 0)
                sink_calm = !sink_calm;
            hold = sink_calm ? 0 : $urandom_range(0, 15);
            if (hold > 0)
            begin
                out_stall <= 1'b1;
                repeat (hold) @(posedge clk);
            end
            out_stall <= 1'b0;
            do @(posedge clk); while (!out_valid);
        end
    end

    task automatic push_pixel(input logic [PIX_W-1:0] px);
        int gap;
        if ($urandom_range(0, 31) == 0)
            source_calm = !source_calm;
        gap = source_calm ? 0 : $urandom_range(0, 15);
        if (gap > 0)
        begin
            in_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        in_valid <= 1'b1;
        pixel    <= px;
        do @(posedge clk); while (in_stall);
        predict_centres(px);
        pixels_sent++;
    endtask

    function automatic logic [PIX_W-1:0] draw_pixel();
        case ($urandom_range(0, 3))
            0: return PIX_W'($urandom_range(0, 3));       // plateaus and ties
            1: return $urandom_range(0, 1) ? '1 : '0;
            2: return PIX_W'($urandom_range(250, 255));
            default: return PIX_W'($urandom);
        endcase
    endfunction

    // Drop valid, let every outstanding result out, then allow the pipe to empty
    task automatic wait_idle();
        in_valid <= 1'b0;
        while (pending_centres.size() != 0)
            @(posedge clk);
        repeat (8) @(posedge clk);
    endtask

    task automatic apb_write(input logic [APB_ADDR_W-1:0] addr,
                             input logic [APB_DATA_W-1:0] data);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= addr;
        pwdata  <= data;
        @(posedge clk);
        penable <= 1'b1;
        do @(posedge clk); while (!pready);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        @(posedge clk);
    endtask

    task automatic apb_read(input logic [APB_ADDR_W-1:0] addr,
                            output logic [APB_DATA_W-1:0] data);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        paddr   <= addr;
        @(posedge clk);
        penable <= 1'b1;
        do
        begin
            @(negedge clk);
            data = prdata;
            @(posedge clk);
        end
        while (!pready);
        psel    <= 1'b0;
        penable <= 1'b0;
        @(posedge clk);
    endtask

    task automatic check_register(input logic [APB_ADDR_W-1:0] addr,
                                  input logic [APB_DATA_W-1:0] want);
        logic [APB_DATA_W-1:0] got;
        apb_read(addr, got);
        if (got !== want)
        begin
            if (mismatches < 10)
                $display("%0t register read at %0h: expected %0h, got %0h",
                         $time, addr, want, got);
            mismatches++;
        end
    endtask

    // Both writes restart the frame; each is read back
    task automatic set_frame(input logic [APB_DATA_W-1:0] w_word,
                             input logic [APB_DATA_W-1:0] h_word);
        wait_idle();
        apb_write(WIDTH_ADDR, w_word);
        cfg_width = w_word[CFG_WIDTH_W-1:0];
        row_pos = 0;
        col_pos = 0;
        check_register(WIDTH_ADDR, APB_DATA_W'(cfg_width));
        apb_write(HEIGHT_ADDR, h_word);
        cfg_height = h_word[CFG_HEIGHT_W-1:0];
        row_pos = 0;
        col_pos = 0;
        check_register(HEIGHT_ADDR, APB_DATA_W'(cfg_height));
        settings_used++;
    endtask

    task automatic test_register_reset();
        check_register(WIDTH_ADDR, APB_DATA_W'(WIDTH_RESET));
        check_register(HEIGHT_ADDR, APB_DATA_W'(HEIGHT_RESET));
    endtask

    task automatic test_directed();
        logic [PIX_W-1:0] peak [9]    = '{8'd10, 8'd20, 8'd30, 8'd40, 8'd255,
                                          8'd40, 8'd30, 8'd20, 8'd10};
        logic [PIX_W-1:0] partial [4] = '{8'd200, 8'd0, 8'd0, 8'd100};
        logic [PIX_W-1:0] row_run [4] = '{8'd255, 8'd0, 8'd255, 8'd255};
        // zero sizes act as 1x1: every pixel is a whole frame
        set_frame(0, 0);
        push_pixel(8'd0);
        push_pixel(8'd255);
        push_pixel(8'h5A);
        // full 3x3 frame with a peak, then a partial next frame after the wrap
        set_frame(3, 3);
        foreach (peak[k])
            push_pixel(peak[k]);
        foreach (partial[k])
            push_pixel(partial[k]);
        // restart mid-frame into a flat 2x2 frame: ties all count as maxima
        set_frame(2, 2);
        repeat (4) push_pixel(8'd7);
        // single row, bottom-row results only
        set_frame(4, 1);
        foreach (row_run[k])
            push_pixel(row_run[k]);
    endtask

    task automatic test_random_frames();
        int unsigned           w;
        int unsigned           h;
        int unsigned           count;
        int                    start;
        logic [APB_DATA_W-1:0] w_word;
        logic [APB_DATA_W-1:0] h_word;
        start = pixels_sent;
        while (pixels_sent - start < RANDOM_PIXELS)
        begin
            w = ($urandom_range(0, 7) == 0) ? $urandom_range(11, 40) : $urandom_range(0, 10);
            h = $urandom_range(0, 8);
            w_word = APB_DATA_W'(w);
            h_word = APB_DATA_W'(h);
            // unused upper bits now and then
            if ($urandom_range(0, 4) == 0)
                w_word[APB_DATA_W-1:CFG_WIDTH_W] = (APB_DATA_W-CFG_WIDTH_W)'($urandom);
            if ($urandom_range(0, 4) == 0)
                h_word[APB_DATA_W-1:CFG_HEIGHT_W] = (APB_DATA_W-CFG_HEIGHT_W)'($urandom);
            set_frame(w_word, h_word);
            count = active_width() * active_height() * $urandom_range(1, 2);
            if ($urandom_range(0, 3) == 0)
                count += $urandom_range(1, active_width() * active_height());
            if (count > 160)
                count = 160;
            repeat (count) push_pixel(draw_pixel());
        end
    endtask

    task automatic test_widest_rows();
        // start of a row at the maximum width, then at an oversized width that is clamped
        set_frame(MAX_WIDTH, 1);
        repeat (EDGE_PIXELS) push_pixel(draw_pixel());
        set_frame({CFG_WIDTH_W{1'b1}}, 2);
        repeat (EDGE_PIXELS) push_pixel(draw_pixel());
    endtask

    task automatic test_tallest_column();
        // oversized height clamps to the row limit; one column keeps each row short
        set_frame(1, {CFG_HEIGHT_W{1'b1}});
        repeat (EDGE_PIXELS) push_pixel(draw_pixel());
    endtask

    initial
    begin
        repeat (7) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);
        test_register_reset();
        test_directed();
        test_random_frames();
        test_widest_rows();
        test_tallest_column();
        wait_idle();
        repeat (20) @(posedge clk);
        $display("Sent %0d pixels under %0d frame settings, from 1x1 to clamped sizes.",
                 pixels_sent, settings_used);
        $display("Checked %0d centres, %0d of them flagged as maxima; %0d mismatches.",
                 centres_seen, maxima_seen, mismatches);
        if (mismatches == 0 && pending_centres.size() == 0)
            $display("TB_OK");
        else
            $display("TB_ERROR");
        $finish;
    end

    initial
    begin
        #40ms;
        $display("TB_ERROR");
        $finish;
    end

endmodule

[filelist.f]
hw/rtl/lmd_pkg.sv
hw/rtl/lmd_ram.sv
hw/rtl/local_max_3x3_detector_unit.sv
tb/tb_local_max_3x3_detector_unit.sv
